// ===== hw/rtl/bpa_pkg.sv =====
// Shared types, codes and helpers of the buddy page allocator.
package bpa_pkg;

   localparam int CNT_W = 15;

   localparam logic [1:0] FN_ALLOC   = 2'd0;
   localparam logic [1:0] FN_FREE    = 2'd1;
   localparam logic [1:0] FN_REBUILD = 2'd2;

   localparam logic [1:0] CSR_REGION_START = 2'd0;
   localparam logic [1:0] CSR_REGION_PAGES = 2'd1;
   localparam logic [1:0] CSR_TOTAL_PAGES  = 2'd2;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ZERO      = 3'd1,
      ST_NPOW2     = 3'd2,
      ST_TOO_LARGE = 3'd3,
      ST_NO_MEM    = 3'd4,
      ST_MISMATCH  = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [14:0] page_count;
      logic [13:0] block_index;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [13:0] alloc_index;
      logic [3:0]  block_order;
      logic [14:0] free_count;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE      = 5'd0,
      OP_LATCH     = 5'd1,
      OP_CLR_INIT  = 5'd2,
      OP_CLR_STEP  = 5'd3,
      OP_CV_DEC    = 5'd4,
      OP_CV_PUSH   = 5'd5,
      OP_PUSH_B    = 5'd6,
      OP_AL_START  = 5'd7,
      OP_AL_UNLINK = 5'd8,
      OP_SPLIT     = 5'd9,
      OP_AL_FIN    = 5'd10,
      OP_FR_START  = 5'd11,
      OP_BUD_RD    = 5'd12,
      OP_MERGE     = 5'd13,
      OP_FR_PUSH   = 5'd14,
      OP_SET_ST    = 5'd15,
      OP_RESULT    = 5'd16
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type code;
   } cmd_type;

   typedef struct packed {
      status_type pre_status;
      logic [1:0] func;
      logic       clr_last;
      logic       carve_more;
      logic       carve_fit;
      logic       split_more;
      logic       order_bad;
      logic       bud_ok;
      logic       merge_ok;
      logic       out_free;
   } sts_type;

   // ceiling log2 of a page count
   function automatic logic [3:0] order_of(input logic [14:0] n);
      logic [3:0] o;
      o = 4'd0;
      for (int i = 0; i < 15; i++) begin
         if ({1'b0, n} > (16'd1 << i)) o = 4'(i + 1);
      end
      return o;
   endfunction

endpackage

// ===== hw/rtl/bpa_ram.sv =====
// Generic single write, single registered read RAM.
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

// ===== hw/rtl/bpa_ctrl.sv =====
// Buddy allocator sequencer: one datapath command per cycle unless stalled.
module bpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bpa_pkg::sts_type sts,
   output bpa_pkg::cmd_type cmd
);
   import bpa_pkg::*;

   typedef enum logic [16:0] {
      S_RST_CLR   = 17'h00001,
      S_IDLE      = 17'h00002,
      S_DECODE    = 17'h00004,
      S_RB_INIT   = 17'h00008,
      S_RB_CLR    = 17'h00010,
      S_RB_FIT    = 17'h00020,
      S_CV_PB     = 17'h00040,
      S_AL_START  = 17'h00080,
      S_AL_UNLINK = 17'h00100,
      S_AL_SPLIT  = 17'h00200,
      S_SP_PB     = 17'h00400,
      S_FR_START  = 17'h00800,
      S_FR_CHK    = 17'h01000,
      S_FR_BUD    = 17'h02000,
      S_FR_BCHK   = 17'h04000,
      S_FR_PB     = 17'h08000,
      S_DONE      = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      cmd.code  = ST_OK;
      req_ready = 1'b0;
      case (state_ff)
         S_RST_CLR: begin
            cmd.op = OP_CLR_STEP;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.pre_status != ST_OK) begin
               cmd.op   = OP_SET_ST;
               cmd.code = sts.pre_status;
               state_in = S_DONE;
            end else if (sts.func == FN_ALLOC) begin
               state_in = S_AL_START;
            end else if (sts.func == FN_FREE) begin
               state_in = S_FR_START;
            end else if (sts.func == FN_REBUILD) begin
               state_in = S_RB_INIT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RB_INIT: begin
            cmd.op   = OP_CLR_INIT;
            state_in = S_RB_CLR;
         end
         S_RB_CLR: begin
            cmd.op = OP_CLR_STEP;
            if (sts.clr_last) state_in = S_RB_FIT;
         end
         S_RB_FIT: begin
            if (!sts.carve_more) begin
               state_in = S_DONE;
            end else if (sts.carve_fit) begin
               cmd.op   = OP_CV_PUSH;
               state_in = S_CV_PB;
            end else begin
               cmd.op = OP_CV_DEC;
            end
         end
         S_CV_PB: begin
            cmd.op   = OP_PUSH_B;
            state_in = S_RB_FIT;
         end
         S_AL_START: begin
            cmd.op   = OP_AL_START;
            state_in = S_AL_UNLINK;
         end
         S_AL_UNLINK: begin
            cmd.op   = OP_AL_UNLINK;
            state_in = S_AL_SPLIT;
         end
         S_AL_SPLIT: begin
            if (sts.split_more) begin
               cmd.op   = OP_SPLIT;
               state_in = S_SP_PB;
            end else begin
               cmd.op   = OP_AL_FIN;
               state_in = S_DONE;
            end
         end
         S_SP_PB: begin
            cmd.op   = OP_PUSH_B;
            state_in = S_AL_SPLIT;
         end
         S_FR_START: begin
            cmd.op   = OP_FR_START;
            state_in = S_FR_CHK;
         end
         S_FR_CHK: begin
            if (sts.order_bad) begin
               cmd.op   = OP_SET_ST;
               cmd.code = ST_MISMATCH;
               state_in = S_DONE;
            end else begin
               state_in = S_FR_BUD;
            end
         end
         S_FR_BUD: begin
            if (sts.bud_ok) begin
               cmd.op   = OP_BUD_RD;
               state_in = S_FR_BCHK;
            end else begin
               cmd.op   = OP_FR_PUSH;
               state_in = S_FR_PB;
            end
         end
         S_FR_BCHK: begin
            if (sts.merge_ok) begin
               cmd.op   = OP_MERGE;
               state_in = S_FR_BUD;
            end else begin
               cmd.op   = OP_FR_PUSH;
               state_in = S_FR_PB;
            end
         end
         S_FR_PB: begin
            cmd.op   = OP_PUSH_B;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_RST_CLR;
      else       state_ff <= state_in;
   end
endmodule

// ===== hw/rtl/bpa_datapath.sv =====
// Datapath: page RAMs, free list heads and counts, configuration and result registers.
module bpa_datapath #(
   parameter int MAX_ORDER_P = 14,
   parameter int PAGES       = 16384
) (
   input  logic             clock,
   input  logic             reset,
   input  bpa_pkg::req_type req_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [14:0]      csr_wdata,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output bpa_pkg::rsp_type rsp_data,
   input  bpa_pkg::cmd_type cmd,
   output bpa_pkg::sts_type sts
);
   import bpa_pkg::*;

   localparam int AW   = $clog2(PAGES);
   localparam int PW   = $clog2(PAGES + 1);
   localparam int NORD = MAX_ORDER_P + 1;
   localparam int HIW  = $clog2(NORD);
   localparam int OW0  = $clog2(MAX_ORDER_P + 2);
   localparam int OW   = (OW0 > 4) ? OW0 : 4;
   localparam int ORW  = (MAX_ORDER_P > 1) ? $clog2(MAX_ORDER_P + 1) : 1;
   localparam int VW0  = (MAX_ORDER_P + 2 > PW + 1) ? MAX_ORDER_P + 2 : PW + 1;
   localparam int VW   = (VW0 > 16) ? VW0 : 16;
   localparam logic [PW-1:0] NIL_P = PW'(PAGES);
   localparam logic [VW-1:0] NIL_V = VW'(PAGES);
   localparam logic [OW-1:0] MAX_O = OW'(MAX_ORDER_P);

   // registers
   logic [1:0]       func_ff, func_in;
   logic [14:0]      cnt_ff, cnt_in;
   logic [13:0]      blk_ff, blk_in;
   logic [OW-1:0]    o_ff, o_in, co_ff, co_in;
   logic [AW-1:0]    pg_ff, pg_in, psave_ff, psave_in, clr_addr_ff, clr_addr_in;
   logic [PW-1:0]    hsave_ff, hsave_in, pos_ff, pos_in, n_ff, n_in;
   logic [PW-1:0]    head_ff [NORD];
   logic [PW-1:0]    head_in [NORD];
   logic [CNT_W-1:0] count_ff [NORD];
   logic [CNT_W-1:0] count_in [NORD];
   logic [CNT_W-1:0] free_ff, free_in;
   status_type       rst_ff, rst_in;
   logic [13:0]      raidx_ff, raidx_in;
   logic [3:0]       rbord_ff, rbord_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [13:0]      rstart_ff, rstart_in;
   logic [14:0]      rpages_ff, rpages_in, tpages_ff, tpages_in;

   // RAM ports
   logic            flag_we, order_we, next_we, prev_we;
   logic [AW-1:0]   flag_wa, order_wa, next_wa, prev_wa, rd_addr;
   logic            flag_wd, flag_rd;
   logic [ORW-1:0]  order_wd, order_rd;
   logic [PW-1:0]   next_wd, next_rd, prev_wd, prev_rd;

   // helpers
   logic [NORD-1:0] nonempty;
   logic [HIW-1:0]  maxo, co_sel, hd_idx, unl_ord, push_ord;
   logic            co_found, push_en, unl_en;
   logic [PW-1:0]   head_rd;
   logic [OW-1:0]   o_req, co_m1;
   logic [VW-1:0]   b_v, split_b, idx_v, size_v, lim_v;
   logic [AW-1:0]   push_p, unl_t;
   status_type      pre_status;

   bpa_ram #(.WIDTH(1), .DEPTH(PAGES)) u_flag (
      .clock(clock), .we(flag_we), .waddr(flag_wa), .wdata(flag_wd),
      .raddr(rd_addr), .rdata(flag_rd));
   bpa_ram #(.WIDTH(ORW), .DEPTH(PAGES)) u_order (
      .clock(clock), .we(order_we), .waddr(order_wa), .wdata(order_wd),
      .raddr(rd_addr), .rdata(order_rd));
   bpa_ram #(.WIDTH(PW), .DEPTH(PAGES)) u_next (
      .clock(clock), .we(next_we), .waddr(next_wa), .wdata(next_wd),
      .raddr(rd_addr), .rdata(next_rd));
   bpa_ram #(.WIDTH(PW), .DEPTH(PAGES)) u_prev (
      .clock(clock), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
      .raddr(rd_addr), .rdata(prev_rd));

   always_comb begin
      maxo     = '0;
      co_sel   = '0;
      co_found = 1'b0;
      o_req    = OW'(order_of(cnt_ff));
      for (int k = 0; k < NORD; k++) begin
         nonempty[k] = |count_ff[k];
         if (nonempty[k]) maxo = HIW'(k);
      end
      for (int k = NORD - 1; k >= 0; k--) begin
         if (nonempty[k] && (OW'(k) >= o_req)) begin
            co_sel   = HIW'(k);
            co_found = 1'b1;
         end
      end
      co_m1 = co_ff - OW'(1);

      if (cnt_ff == 15'd0) begin
         pre_status = ST_ZERO;
      end else if (func_ff == FN_ALLOC) begin
         if (VW'(cnt_ff) > (VW'(1) << maxo))              pre_status = ST_TOO_LARGE;
         else if ((cnt_ff & (cnt_ff - 15'd1)) != 15'd0)   pre_status = ST_NPOW2;
         else if (!co_found || head_ff[co_sel] >= NIL_P)  pre_status = ST_NO_MEM;
         else                                             pre_status = ST_OK;
      end else if (func_ff == FN_FREE) begin
         pre_status = (VW'(blk_ff) >= NIL_V) ? ST_MISMATCH : ST_OK;
      end else begin
         pre_status = ST_OK;
      end
      if (cnt_ff == 15'd0 && func_ff != FN_ALLOC && func_ff != FN_FREE) pre_status = ST_OK;

      b_v     = VW'(pg_ff) ^ (VW'(1) << o_ff);
      split_b = VW'(pg_ff) ^ (VW'(1) << co_m1);
      idx_v   = VW'(rstart_ff) + VW'(pos_ff);
      size_v  = VW'(1) << o_ff;
      lim_v   = NIL_V - VW'(rstart_ff);

      sts.pre_status = pre_status;
      sts.func       = func_ff;
      sts.clr_last   = (clr_addr_ff == AW'(PAGES - 1));
      sts.carve_more = (pos_ff < n_ff);
      sts.carve_fit  = (((idx_v & (size_v - VW'(1))) == '0)
                        && (VW'(pos_ff) + size_v <= VW'(n_ff))) || (o_ff == '0);
      sts.split_more = (co_ff > o_ff);
      sts.order_bad  = flag_rd || (OW'(order_rd) != o_ff);
      sts.bud_ok     = (o_ff < MAX_O) && (b_v < VW'(tpages_ff)) && (b_v < NIL_V);
      sts.merge_ok   = flag_rd && (OW'(order_rd) == o_ff);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      case (cmd.op)
         OP_CV_PUSH, OP_FR_PUSH: hd_idx = o_ff[HIW-1:0];
         OP_SPLIT:               hd_idx = co_m1[HIW-1:0];
         default:                hd_idx = co_sel;
      endcase
      head_rd = head_ff[hd_idx];
   end

   always_comb begin
      func_in      = func_ff;
      cnt_in       = cnt_ff;
      blk_in       = blk_ff;
      o_in         = o_ff;
      co_in        = co_ff;
      pg_in        = pg_ff;
      psave_in     = psave_ff;
      hsave_in     = hsave_ff;
      clr_addr_in  = clr_addr_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      free_in      = free_ff;
      rst_in       = rst_ff;
      raidx_in     = raidx_ff;
      rbord_in     = rbord_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rstart_in    = rstart_ff;
      rpages_in    = rpages_ff;
      tpages_in    = tpages_ff;

      flag_we  = 1'b0; flag_wa  = '0; flag_wd  = 1'b0;
      order_we = 1'b0; order_wa = '0; order_wd = '0;
      next_we  = 1'b0; next_wa  = '0; next_wd  = '0;
      prev_we  = 1'b0; prev_wa  = '0; prev_wd  = '0;
      rd_addr  = '0;
      push_en  = 1'b0; push_p   = '0; push_ord = '0;
      unl_en   = 1'b0; unl_t    = '0; unl_ord  = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_REGION_START: rstart_in = csr_wdata[13:0];
            CSR_REGION_PAGES: rpages_in = csr_wdata;
            CSR_TOTAL_PAGES:  tpages_in = csr_wdata;
            default: ;
         endcase
      end

      case (cmd.op)
         OP_LATCH: begin
            func_in  = req_data.func;
            cnt_in   = req_data.page_count;
            blk_in   = req_data.block_index;
            rst_in   = ST_OK;
            raidx_in = '0;
            rbord_in = '0;
         end
         OP_CLR_INIT: begin
            for (int k = 0; k < NORD; k++) begin
               head_in[k]  = NIL_P;
               count_in[k] = '0;
            end
            free_in     = '0;
            clr_addr_in = '0;
            pos_in      = '0;
            o_in        = MAX_O;
            if (VW'(rstart_ff) < NIL_V)
               n_in = (VW'(rpages_ff) < lim_v) ? PW'(rpages_ff) : PW'(lim_v);
            else
               n_in = '0;
         end
         OP_CLR_STEP: begin
            flag_we     = 1'b1;
            flag_wa     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         OP_CV_DEC: o_in = o_ff - OW'(1);
         OP_CV_PUSH: begin
            push_en  = 1'b1;
            push_p   = idx_v[AW-1:0];
            push_ord = o_ff[HIW-1:0];
            free_in  = free_ff + size_v[CNT_W-1:0];
            pos_in   = pos_ff + size_v[PW-1:0];
            o_in     = MAX_O;
         end
         OP_PUSH_B: begin
            if (hsave_ff < NIL_P) begin
               prev_we = 1'b1;
               prev_wa = hsave_ff[AW-1:0];
               prev_wd = PW'(psave_ff);
            end
         end
         OP_AL_START: begin
            co_in   = OW'(co_sel);
            pg_in   = head_rd[AW-1:0];
            o_in    = o_req;
            rd_addr = head_rd[AW-1:0];
         end
         OP_AL_UNLINK: begin
            unl_en  = 1'b1;
            unl_t   = pg_ff;
            unl_ord = co_ff[HIW-1:0];
         end
         OP_SPLIT: begin
            co_in = co_m1;
            if (split_b < NIL_V) begin
               push_en  = 1'b1;
               push_p   = split_b[AW-1:0];
               push_ord = co_m1[HIW-1:0];
            end else begin
               hsave_in = NIL_P;
            end
         end
         OP_AL_FIN: begin
            order_we = 1'b1;
            order_wa = pg_ff;
            order_wd = ORW'(o_ff);
            flag_we  = 1'b1;
            flag_wa  = pg_ff;
            free_in  = free_ff - cnt_ff;
            raidx_in = 14'(pg_ff);
            rbord_in = o_ff[3:0];
         end
         OP_FR_START: begin
            o_in    = o_req;
            pg_in   = AW'(blk_ff);
            rd_addr = AW'(blk_ff);
         end
         OP_BUD_RD: rd_addr = b_v[AW-1:0];
         OP_MERGE: begin
            unl_en  = 1'b1;
            unl_t   = b_v[AW-1:0];
            unl_ord = o_ff[HIW-1:0];
            if (b_v < VW'(pg_ff)) pg_in = b_v[AW-1:0];
            o_in = o_ff + OW'(1);
         end
         OP_FR_PUSH: begin
            push_en  = 1'b1;
            push_p   = pg_ff;
            push_ord = o_ff[HIW-1:0];
            free_in  = free_ff + cnt_ff;
            rbord_in = o_ff[3:0];
         end
         OP_SET_ST: rst_in = cmd.code;
         OP_RESULT: begin
            rsp_in.status      = rst_ff;
            rsp_in.alloc_index = raidx_ff;
            rsp_in.block_order = rbord_ff;
            rsp_in.free_count  = free_ff;
            rsp_valid_in       = 1'b1;
         end
         default: ;
      endcase

      if (push_en) begin
         flag_we            = 1'b1;
         flag_wa            = push_p;
         flag_wd            = 1'b1;
         order_we           = 1'b1;
         order_wa           = push_p;
         order_wd           = ORW'(push_ord);
         next_we            = 1'b1;
         next_wa            = push_p;
         next_wd            = head_rd;
         prev_we            = 1'b1;
         prev_wa            = push_p;
         prev_wd            = NIL_P;
         head_in[push_ord]  = PW'(push_p);
         count_in[push_ord] = count_ff[push_ord] + CNT_W'(1);
         hsave_in           = head_rd;
         psave_in           = push_p;
      end

      if (unl_en) begin
         if (prev_rd < NIL_P) begin
            next_we = 1'b1;
            next_wa = prev_rd[AW-1:0];
            next_wd = next_rd;
         end else begin
            head_in[unl_ord] = next_rd;
         end
         if (next_rd < NIL_P) begin
            prev_we = 1'b1;
            prev_wa = next_rd[AW-1:0];
            prev_wd = prev_rd;
         end
         flag_we           = 1'b1;
         flag_wa           = unl_t;
         count_in[unl_ord] = count_ff[unl_ord] - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NORD; k++) begin
            head_ff[k]  <= NIL_P;
            count_ff[k] <= '0;
         end
         free_ff      <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rstart_ff    <= '0;
         rpages_ff    <= 15'd16384;
         tpages_ff    <= 15'd16384;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         rstart_ff    <= rstart_in;
         rpages_ff    <= rpages_in;
         tpages_ff    <= tpages_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      cnt_ff   <= cnt_in;
      blk_ff   <= blk_in;
      o_ff     <= o_in;
      co_ff    <= co_in;
      pg_ff    <= pg_in;
      psave_ff <= psave_in;
      hsave_ff <= hsave_in;
      pos_ff   <= pos_in;
      n_ff     <= n_in;
      rst_ff   <= rst_in;
      raidx_ff <= raidx_in;
      rbord_ff <= rbord_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ===== hw/rtl/buddy_page_allocator.sv =====
// Buddy page allocator top level: sequencer plus datapath.
// Allocate: latch, decode, start, unlink, one split and push per split order, finish;
// rejected items go from decode to the result. Free: start, order check, then a buddy read
// and merge per merged order, then the push; an order mismatch goes from check to result.
// Rebuild: flag sweep, then carving into blocks. One item at a time; the result register
// lets the next transfer in while a result waits. After reset the head-flag RAM is swept
// with req_ready low; configuration writes are taken throughout.
module buddy_page_allocator #(
   parameter int MAX_ORDER_P = 14,
   parameter int PAGES       = 16384
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bpa_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [14:0]      csr_wdata
);
   import bpa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bpa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .sts(sts), .cmd(cmd));

   bpa_datapath #(.MAX_ORDER_P(MAX_ORDER_P), .PAGES(PAGES)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_ready(rsp_ready), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .cmd(cmd), .sts(sts));

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer taken while busy");

   a_latch_on_transfer: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_LATCH |-> req_valid && req_ready)
      else $error("request latched without a transfer");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_RESULT |-> !rsp_valid || rsp_ready)
      else $error("result overwritten before transfer");
endmodule
